// ----- rtl/sdm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the signed 64-bit divide/modulo pipeline.
// No dependencies.
package sdm_pkg;

    localparam int FIELD_WIDTH = 64;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic zero;
    } t_sdm_flags;

endpackage
`default_nettype wire

// ----- rtl/sdm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the divide request and response items.
// Depends on sdm_pkg.
interface sdm_in_if import sdm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] dividend;
    logic signed [FIELD_WIDTH-1:0] divisor;

    modport source (output valid, dividend, divisor, input ready);
    modport sink   (input valid, dividend, divisor, output ready);
endinterface

interface sdm_out_if import sdm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] quotient;
    logic signed [FIELD_WIDTH-1:0] remainder;

    modport source (output valid, quotient, remainder, input ready);
    modport sink   (input valid, quotient, remainder, output ready);
endinterface
`default_nettype wire

// ----- rtl/sdm_pre.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input stage: narrows the operands, takes magnitudes, records the signs and flags a zero divisor.
// Depends on sdm_pkg.
module sdm_pre import sdm_pkg::*; #(
    parameter int W = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [FIELD_WIDTH-1:0] i_dividend,
    input  wire logic [FIELD_WIDTH-1:0] i_divisor,
    output logic                        o_valid,
    output t_sdm_flags                  o_flags,
    output logic [W-1:0]                o_quo,
    output logic [W-1:0]                o_div
);

    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] n_quo;
    logic [W-1:0] n_div;
    t_sdm_flags   n_flags;
    logic         r_valid;
    t_sdm_flags   r_flags;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_div;

    always_comb begin
        a             = i_dividend[W-1:0];
        b             = i_divisor[W-1:0];
        n_quo         = a[W-1] ? (~a + W'(1)) : a;
        n_div         = b[W-1] ? (~b + W'(1)) : b;
        n_flags.neg_a = a[W-1];
        n_flags.neg_b = b[W-1];
        n_flags.zero  = (b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
            r_quo   <= n_quo;
            r_div   <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_quo   = r_quo;
    assign o_div   = r_div;

endmodule
`default_nettype wire

// ----- rtl/sdm_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step: shifts in a dividend bit, trial subtract,
// emits one quotient bit. Depends on sdm_pkg.
module sdm_step import sdm_pkg::*; #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire t_sdm_flags   i_flags,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_quo,
    input  wire logic [W-1:0] i_div,
    output logic              o_valid,
    output t_sdm_flags        o_flags,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_quo,
    output logic [W-1:0]      o_div
);

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         take;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_quo;
    logic         r_valid;
    t_sdm_flags   r_flags;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_div;

    always_comb begin
        shifted = {i_rem, i_quo[W-1]};
        diff    = shifted - {1'b0, i_div};
        take    = ~diff[W];
        n_rem   = take ? diff[W-1:0] : shifted[W-1:0];
        n_quo   = {i_quo[W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_div   <= i_div;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_div   = r_div;

endmodule
`default_nettype wire

// ----- rtl/sdm_post.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Output stage: applies signs, forces the divide-by-zero quotient, widens
// to 64 bits and holds the result item. Depends on sdm_pkg.
module sdm_post import sdm_pkg::*; #(
    parameter int W = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire t_sdm_flags             i_flags,
    input  wire logic [W-1:0]           i_quo,
    input  wire logic [W-1:0]           i_rem,
    output logic                        o_valid,
    output logic [FIELD_WIDTH-1:0]      o_quotient,
    output logic [FIELD_WIDTH-1:0]      o_remainder
);

    logic [W-1:0]           q;
    logic [W-1:0]           r;
    logic                   r_valid;
    logic [FIELD_WIDTH-1:0] r_quotient;
    logic [FIELD_WIDTH-1:0] r_remainder;

    always_comb begin
        if (i_flags.zero) begin
            q = '0;
        end else if (i_flags.neg_a ^ i_flags.neg_b) begin
            q = ~i_quo + W'(1);
        end else begin
            q = i_quo;
        end
        r = i_flags.neg_a ? (~i_rem + W'(1)) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quotient  <= FIELD_WIDTH'($signed(q));
            r_remainder <= FIELD_WIDTH'($signed(r));
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;

endmodule
`default_nettype wire

// ----- rtl/signed_divmod_64_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Signed divide/modulo core: quotient truncated toward zero, remainder with
// the dividend's sign; divisor zero gives quotient 0 and remainder equal to
// the dividend, and the minimum over minus one wraps with remainder 0.
// Operands use their low DATA_WIDTH bits; results are sign-extended to 64.
// Fully pipelined restoring divider: one item per cycle while no result
// waits at the output, through an input stage, one stage per quotient bit
// and an output stage. The whole pipeline stalls while a result waits at the output.
// Depends on sdm_pkg, sdm_if, sdm_pre, sdm_step and sdm_post.
module signed_divmod_64_core import sdm_pkg::*; #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sdm_in_if.sink     i_req,
    sdm_out_if.source  o_rsp
);

    localparam int W = DATA_WIDTH;

    logic           en;
    logic           s_valid [0:W];
    t_sdm_flags     s_flags [0:W];
    logic [W-1:0]   s_rem   [0:W];
    logic [W-1:0]   s_quo   [0:W];
    logic [W-1:0]   s_div   [0:W];
    logic           post_valid;

    assign en          = ~post_valid | o_rsp.ready;
    assign i_req.ready = en;
    assign s_rem[0]    = '0;

    sdm_pre #(.W(W)) u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_dividend (i_req.dividend),
        .i_divisor  (i_req.divisor),
        .o_valid    (s_valid[0]),
        .o_flags    (s_flags[0]),
        .o_quo      (s_quo[0]),
        .o_div      (s_div[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_step
        sdm_step #(.W(W)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[k]),
            .i_flags (s_flags[k]),
            .i_rem   (s_rem[k]),
            .i_quo   (s_quo[k]),
            .i_div   (s_div[k]),
            .o_valid (s_valid[k+1]),
            .o_flags (s_flags[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_quo   (s_quo[k+1]),
            .o_div   (s_div[k+1])
        );
    end

    sdm_post #(.W(W)) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (s_valid[W]),
        .i_flags     (s_flags[W]),
        .i_quo       (s_quo[W]),
        .i_rem       (s_rem[W]),
        .o_valid     (post_valid),
        .o_quotient  (o_rsp.quotient),
        .o_remainder (o_rsp.remainder)
    );

    assign o_rsp.valid = post_valid;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> s_valid[0])
        else $error("accepted item missing from input stage");

    a_last_step_exits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_valid[W] && en) |=> o_rsp.valid)
        else $error("item lost between last step and output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_rsp.valid && !s_valid[0]))
        else $error("valid set right after reset");

endmodule
`default_nettype wire
